>>> hdl/dda_pkg.sv
`timescale 1ns / 1ps

package dda_pkg;

  localparam int DefCoordBits = 12;
  localparam int DefFracBits  = 16;
  localparam int QueueDepth   = 4;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } dda_req_t;

  typedef enum logic {
    B_IDLE,
    B_DIV
  } dda_bstate_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dda_qstat_t;

  // Queue entry: kind, x_start, y_start, dx_neg, dy_neg, dx_mag, dy_mag, len.
  function automatic int entry_width(input int coord_bits);
    return 3 + 2 * coord_bits + 3 * (coord_bits + 1);
  endfunction

endpackage

>>> hdl/dda_front.sv
`timescale 1ns / 1ps

module dda_front #(
  parameter int COORD_BITS = dda_pkg::DefCoordBits
) (
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         req_type,
  input  logic signed [COORD_BITS-1:0]                 x_start,
  input  logic signed [COORD_BITS-1:0]                 y_start,
  input  logic signed [COORD_BITS-1:0]                 x_end,
  input  logic signed [COORD_BITS-1:0]                 y_end,
  input  dda_pkg::dda_qstat_t                          qstat,
  output logic                                         push,
  output logic [dda_pkg::entry_width(COORD_BITS)-1:0]  entry
);
  import dda_pkg::*;

  localparam int LEN_W = COORD_BITS + 1;

  typedef struct packed {
    dda_req_t                 kind;
    logic [COORD_BITS-1:0]    xs;
    logic [COORD_BITS-1:0]    ys;
    logic                     dx_neg;
    logic                     dy_neg;
    logic [LEN_W-1:0]         dx_mag;
    logic [LEN_W-1:0]         dy_mag;
    logic [LEN_W-1:0]         len;
  } entry_t;

  entry_t           ent;
  logic [LEN_W-1:0] dx;
  logic [LEN_W-1:0] dy;

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  assign dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
  assign dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};

  always_comb begin
    ent        = '0;
    ent.kind   = dda_req_t'(req_type);
    ent.xs     = x_start;
    ent.ys     = y_start;
    ent.dx_neg = dx[LEN_W-1];
    ent.dy_neg = dy[LEN_W-1];
    ent.dx_mag = dx[LEN_W-1] ? (~dx + LEN_W'(1)) : dx;
    ent.dy_mag = dy[LEN_W-1] ? (~dy + LEN_W'(1)) : dy;
    ent.len    = (ent.dx_mag >= ent.dy_mag) ? ent.dx_mag : ent.dy_mag;
  end

  assign entry = ent;

endmodule

>>> hdl/dda_queue.sv
`timescale 1ns / 1ps

module dda_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dda_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output dda_pkg::dda_qstat_t  qstat
);
  import dda_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign rdata       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/dda_back.sv
`timescale 1ns / 1ps

module dda_back #(
  parameter int COORD_BITS = dda_pkg::DefCoordBits,
  parameter int FRAC_BITS  = dda_pkg::DefFracBits
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic [dda_pkg::entry_width(COORD_BITS)-1:0]  entry,
  input  dda_pkg::dda_qstat_t                          qstat,
  output logic                                         pop,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic signed [COORD_BITS-1:0]                 pixel_x,
  output logic signed [COORD_BITS-1:0]                 pixel_y,
  output logic                                         last_point
);
  import dda_pkg::*;

  localparam int LEN_W  = COORD_BITS + 1;
  localparam int REM_W  = LEN_W + 1;
  localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);

  typedef struct packed {
    dda_req_t                 kind;
    logic [COORD_BITS-1:0]    xs;
    logic [COORD_BITS-1:0]    ys;
    logic                     dx_neg;
    logic                     dy_neg;
    logic [LEN_W-1:0]         dx_mag;
    logic [LEN_W-1:0]         dy_mag;
    logic [LEN_W-1:0]         len;
  } entry_t;

  entry_t      head;
  dda_bstate_t state;
  dda_bstate_t state_next;

  logic [ACC_W-1:0]  acc_x;
  logic [ACC_W-1:0]  acc_y;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;
  logic [LEN_W-1:0]  points_left;
  logic [LEN_W-1:0]  divisor;
  logic [LEN_W-1:0]  rem_x;
  logic [LEN_W-1:0]  rem_y;
  logic [Q_W-1:0]    quo_x;
  logic [Q_W-1:0]    quo_y;
  logic              neg_x;
  logic              neg_y;
  logic [CNT_W-1:0]  div_cnt;

  logic              div_run;
  logic              load_pop;
  logic              point_fire;
  logic [REM_W-1:0]  shx;
  logic [REM_W-1:0]  shy;
  logic              ge_x;
  logic              ge_y;
  logic [LEN_W-1:0]  rem_x_next;
  logic [LEN_W-1:0]  rem_y_next;
  logic [Q_W-1:0]    quo_x_next;
  logic [Q_W-1:0]    quo_y_next;
  logic              ge0_x;
  logic              ge0_y;
  logic [ACC_W-1:0]  half;
  logic [ACC_W-1:0]  base_x;
  logic [ACC_W-1:0]  base_y;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;

  assign head = entry;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (pop && head.kind == REQ_LOAD && head.len != '0) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (div_cnt == CNT_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // FSM outputs. A load never needs the output register, so it may pass a stalled result.
  always_comb begin
    pop     = 1'b0;
    div_run = 1'b0;
    case (state)
      B_IDLE: begin
        pop = !qstat.empty && (head.kind == REQ_LOAD || !out_valid || !out_stall);
      end
      B_DIV: begin
        div_run = 1'b1;
      end
      default: begin
        pop     = 1'b0;
        div_run = 1'b0;
      end
    endcase
  end

  assign load_pop   = pop && head.kind == REQ_LOAD;
  assign point_fire = pop && head.kind == REQ_STEP && points_left != '0;

  // One quotient bit per cycle on each axis; the remainder stays below the divisor.
  assign shx        = {rem_x, 1'b0};
  assign shy        = {rem_y, 1'b0};
  assign ge_x       = shx >= {1'b0, divisor};
  assign ge_y       = shy >= {1'b0, divisor};
  assign rem_x_next = ge_x ? LEN_W'(shx - {1'b0, divisor}) : shx[LEN_W-1:0];
  assign rem_y_next = ge_y ? LEN_W'(shy - {1'b0, divisor}) : shy[LEN_W-1:0];
  assign quo_x_next = {quo_x[Q_W-2:0], ge_x};
  assign quo_y_next = {quo_y[Q_W-2:0], ge_y};

  assign ge0_x  = head.dx_mag >= head.len;
  assign ge0_y  = head.dy_mag >= head.len;
  assign half   = ACC_W'(1) << (FRAC_BITS - 1);
  assign base_x = {head.xs[COORD_BITS-1], head.xs, {FRAC_BITS{1'b0}}};
  assign base_y = {head.ys[COORD_BITS-1], head.ys, {FRAC_BITS{1'b0}}};

  // Truncation toward zero: a negative value with a fraction rounds up by one.
  assign pix_x = acc_x[FRAC_BITS +: COORD_BITS]
               + COORD_BITS'(acc_x[ACC_W-1] && (acc_x[FRAC_BITS-1:0] != '0));
  assign pix_y = acc_y[FRAC_BITS +: COORD_BITS]
               + COORD_BITS'(acc_y[ACC_W-1] && (acc_y[FRAC_BITS-1:0] != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      out_valid   <= 1'b0;
      points_left <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      step_x      <= '0;
      step_y      <= '0;
      div_cnt     <= '0;
    end else begin
      state <= state_next;

      if (point_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (load_pop) begin
        acc_x       <= base_x + (head.dx_neg ? (~half + ACC_W'(1)) : half);
        acc_y       <= base_y + (head.dy_neg ? (~half + ACC_W'(1)) : half);
        points_left <= head.len;
        step_x      <= '0;
        step_y      <= '0;
        div_cnt     <= CNT_W'(FRAC_BITS);
      end else if (point_fire) begin
        acc_x       <= acc_x + {{(ACC_W - STEP_W){step_x[STEP_W-1]}}, step_x};
        acc_y       <= acc_y + {{(ACC_W - STEP_W){step_y[STEP_W-1]}}, step_y};
        points_left <= points_left - LEN_W'(1);
      end

      if (div_run) begin
        div_cnt <= div_cnt - CNT_W'(1);
        if (div_cnt == CNT_W'(1)) begin
          step_x <= neg_x ? (~{1'b0, quo_x_next} + STEP_W'(1)) : {1'b0, quo_x_next};
          step_y <= neg_y ? (~{1'b0, quo_y_next} + STEP_W'(1)) : {1'b0, quo_y_next};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pop) begin
      divisor <= head.len;
      neg_x   <= head.dx_neg;
      neg_y   <= head.dy_neg;
      quo_x   <= Q_W'(ge0_x);
      quo_y   <= Q_W'(ge0_y);
      rem_x   <= ge0_x ? (head.dx_mag - head.len) : head.dx_mag;
      rem_y   <= ge0_y ? (head.dy_mag - head.len) : head.dy_mag;
    end else if (div_run) begin
      quo_x <= quo_x_next;
      quo_y <= quo_y_next;
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
    end
    if (point_fire) begin
      pixel_x    <= pix_x;
      pixel_y    <= pix_y;
      last_point <= (points_left == LEN_W'(1));
    end
  end

endmodule

>>> hdl/dda_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// Line rasterizer using a fixed-point DDA.
// Input channel (in_valid / in_stall): req_type 0 loads a line from x_start, y_start,
// x_end, y_end; req_type 1 asks for the next point. Output channel (out_valid /
// out_stall) returns pixel_x, pixel_y and last_point, one transaction per point request
// while a line has points left. Point requests after the last point, and loads, give none.
// A front stage classifies each transaction and computes the axis differences and the
// line length, then writes it into a four-entry queue; the back end drains the queue.
// A point is registered when the back end pops its request. Throughput is one point per
// cycle while the back end is neither dividing nor stalled, set by the accumulator add.
// After it leaves the queue, a nonzero-length load holds the back end while the two-axis
// restoring divider produces one step bit per cycle; the queue still takes requests.
// When out_stall is high the finished point is held in the output register, the back
// end stops draining points (loads still drain) and in_stall rises once the queue fills.
// Synchronous reset empties the queue, drops any pending output and clears the line, so
// point requests emit nothing until the next load.
module dda_line_rasterizer_unit #(
  parameter int COORD_BITS = dda_pkg::DefCoordBits,
  parameter int FRAC_BITS  = dda_pkg::DefFracBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic signed [COORD_BITS-1:0]  x_start,
  input  logic signed [COORD_BITS-1:0]  y_start,
  input  logic signed [COORD_BITS-1:0]  x_end,
  input  logic signed [COORD_BITS-1:0]  y_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic                          last_point
);
  import dda_pkg::*;

  localparam int ENTRY_W = entry_width(COORD_BITS);

  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;
  dda_qstat_t         qstat;

  dda_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .qstat   (qstat),
    .push    (push),
    .entry   (wr_entry)
  );

  dda_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(wr_entry),
    .pop  (pop),
    .rdata(rd_entry),
    .qstat(qstat)
  );

  dda_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (rd_entry),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last_point(last_point)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("back end drained an empty queue");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  a_new_point_from_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(pop))
    else $error("point appeared without a queue transaction");

endmodule
